// ===== design/heron_triangle_area_accumulator_defines.svh =====
// Assertion macros for the Heron triangle area accumulator.
// Bodies refer to clk and rst_n of the module that uses them.
`ifndef HERON_TRIANGLE_AREA_ACCUMULATOR_DEFINES_SVH
`define HERON_TRIANGLE_AREA_ACCUMULATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define HTA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hta: same-cycle check failed");
`define HTA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hta: next-cycle check failed");
`else
`define HTA_ASSERT_IMP(label, ante, cons)
`define HTA_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== design/hta_pkg.sv =====
// Shared widths, types and step codes of the Heron triangle area accumulator.
// No dependencies.
package hta_pkg;

  localparam int COORD_W         = 24;
  localparam int COORD_FRAC_BITS = 8;
  localparam int NUM_AXES        = 3;
  localparam int NUM_DIFF        = 3 * NUM_AXES;
  localparam int EDGE_W          = 25;               // floor(sqrt(3 * (2^24-1)^2))
  localparam int SUMSQ_W         = 2 * EDGE_W;       // sum of three squared differences
  localparam int OP_W            = EDGE_W + 2;       // multiplier operand width
  localparam int PROD_W          = 2 * OP_W;
  localparam int F_W             = EDGE_W + 1;       // non-negative Heron factor
  localparam int P1_W            = OP_W + F_W;       // perimeter * factor
  localparam int P2_W            = 2 * F_W;          // factor * factor
  localparam int RAD_W           = 2 * PROD_W - 2;   // Heron product, 106 bits
  localparam int ROOT_W          = RAD_W / 2;
  localparam int EDGE_ITER       = SUMSQ_W / 2;
  localparam int HERON_ITER      = ROOT_W;
  localparam int ITER_W          = $clog2(HERON_ITER + 1);
  localparam int AREA_W          = 47;

  typedef struct packed {
    logic start;
    logic wide;      // full Heron radicand rather than an edge sum
  } sq_cmd_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ROOT_W-1:0] root;
  } sq_sts_t;

  // multiply steps of the Heron product
  typedef enum logic [2:0] {
    HS_P1 = 3'd0,
    HS_P2 = 3'd1,
    HS_LL = 3'd2,
    HS_LH = 3'd3,
    HS_HL = 3'd4,
    HS_HH = 3'd5
  } hstep_t;

endpackage

// ===== design/hta_sqrt.sv =====
// Bit-serial floored integer square root, one result bit per cycle.
// Depends on hta_pkg.
module hta_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hta_pkg::sq_cmd_t           cmd,
  input  logic [hta_pkg::RAD_W-1:0]  radicand,
  output hta_pkg::sq_sts_t           sts
);

  localparam int RW = hta_pkg::ROOT_W + 4;

  logic [hta_pkg::RAD_W-1:0]  rad_r;
  logic [RW-1:0]              rem_r;
  logic [hta_pkg::ROOT_W-1:0] root_r;
  logic [hta_pkg::ITER_W-1:0] cnt_r;
  logic                       busy_r;
  logic                       done_r;

  logic [RW-1:0] rem_sh;
  logic [RW-1:0] trial;
  logic          ge;

  assign rem_sh = {rem_r[RW-3:0], rad_r[hta_pkg::RAD_W-1 -: 2]};
  assign trial  = {{(RW - hta_pkg::ROOT_W - 2){1'b0}}, root_r, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= cmd.wide ? hta_pkg::ITER_W'(hta_pkg::HERON_ITER)
                           : hta_pkg::ITER_W'(hta_pkg::EDGE_ITER);
      end else if (busy_r) begin
        cnt_r <= cnt_r - hta_pkg::ITER_W'(1);
        if (cnt_r == hta_pkg::ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      // left-align the radicand so that two bits drop in from the top each step
      rad_r  <= cmd.wide ? radicand
                         : {radicand[hta_pkg::SUMSQ_W-1:0],
                            {(hta_pkg::RAD_W - hta_pkg::SUMSQ_W){1'b0}}};
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[hta_pkg::RAD_W-3:0], 2'b00};
      rem_r  <= ge ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[hta_pkg::ROOT_W-2:0], ge};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign sts.root = root_r;

endmodule

// ===== design/heron_triangle_area_accumulator.sv =====
// Heron triangle area accumulator: one triangle per beat in, one result per beat out.
// Each triangle passes through the edge lengths, a prep step, the Heron multiply steps, the root and the output;
// the Heron multiply and root steps are skipped when truncation breaks the triangle inequality.
// A new triangle is taken only once the last one is through; results wait in the output register.
// Synchronous active-low reset clears the sequencer, the output valid and the running total.
// Depends on hta_pkg, hta_sqrt and heron_triangle_area_accumulator_defines.svh.
`include "heron_triangle_area_accumulator_defines.svh"

module heron_triangle_area_accumulator #(
  parameter int COORD_FRAC_BITS = hta_pkg::COORD_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [hta_pkg::COORD_W-1:0] in_p0_x,
  input  logic signed [hta_pkg::COORD_W-1:0] in_p0_y,
  input  logic signed [hta_pkg::COORD_W-1:0] in_p0_z,
  input  logic signed [hta_pkg::COORD_W-1:0] in_p1_x,
  input  logic signed [hta_pkg::COORD_W-1:0] in_p1_y,
  input  logic signed [hta_pkg::COORD_W-1:0] in_p1_z,
  input  logic signed [hta_pkg::COORD_W-1:0] in_p2_x,
  input  logic signed [hta_pkg::COORD_W-1:0] in_p2_y,
  input  logic signed [hta_pkg::COORD_W-1:0] in_p2_z,
  input  logic                               in_is_last_triangle,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [hta_pkg::AREA_W-1:0]         out_triangle_area,
  output logic [hta_pkg::AREA_W-1:0]         out_polygon_area,
  output logic                               out_polygon_done
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_EMUL  = 11'b000_0000_0010,
    S_EACC  = 11'b000_0000_0100,
    S_ESQ   = 11'b000_0000_1000,
    S_EWAIT = 11'b000_0001_0000,
    S_PREP  = 11'b000_0010_0000,
    S_HMUL  = 11'b000_0100_0000,
    S_HACC  = 11'b000_1000_0000,
    S_HSQ   = 11'b001_0000_0000,
    S_HWAIT = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  localparam int AREA_SHIFT = COORD_FRAC_BITS + 2;

  function automatic logic [hta_pkg::COORD_W-1:0] abs_diff(
    input logic signed [hta_pkg::COORD_W-1:0] a,
    input logic signed [hta_pkg::COORD_W-1:0] b
  );
    logic signed [hta_pkg::COORD_W:0] d;
    logic        [hta_pkg::COORD_W:0] n;
    d = {a[hta_pkg::COORD_W-1], a} - {b[hta_pkg::COORD_W-1], b};
    n = -d;
    return d[hta_pkg::COORD_W] ? n[hta_pkg::COORD_W-1:0] : d[hta_pkg::COORD_W-1:0];
  endfunction

  state_t state_r, state_nxt;

  logic [1:0]                    comp_r;
  logic [1:0]                    edge_r;
  hta_pkg::hstep_t               hstep_r;
  logic                          out_valid_r;
  logic [hta_pkg::AREA_W-1:0]    running_total_r;

  logic [hta_pkg::COORD_W-1:0]   dif_r [hta_pkg::NUM_DIFF];
  logic                          last_r;
  logic [hta_pkg::PROD_W-1:0]    mul_r;
  logic [hta_pkg::RAD_W-1:0]     acc_r;
  logic [hta_pkg::EDGE_W-1:0]    ea_r, eb_r, ec_r;
  logic [hta_pkg::OP_W-1:0]      per_r;
  logic [hta_pkg::F_W-1:0]       f1_r, f2_r, f3_r;
  logic [hta_pkg::P1_W-1:0]      p1_r;
  logic [hta_pkg::P2_W-1:0]      p2_r;
  logic [hta_pkg::AREA_W-1:0]    area_r;
  logic [hta_pkg::AREA_W-1:0]    out_tri_r, out_poly_r;
  logic                          out_done_r;

  logic                          in_fire;
  logic                          done_fire;
  logic [hta_pkg::OP_W-1:0]      op_a, op_b;
  logic [hta_pkg::RAD_W-1:0]     prod_ext, addend;
  logic [hta_pkg::OP_W-1:0]      per_c, f1_c, f2_c, f3_c;
  logic                          heron_neg;
  logic [hta_pkg::ROOT_W-1:0]    root_sh;
  logic [hta_pkg::AREA_W-1:0]    area_sat;
  logic [hta_pkg::AREA_W:0]      total_sum;
  logic [hta_pkg::AREA_W-1:0]    total_sat;
  logic [hta_pkg::COORD_W-1:0]   dif_in [hta_pkg::NUM_DIFF];

  hta_pkg::sq_cmd_t              sq_cmd;
  hta_pkg::sq_sts_t              sq_sts;

  assign in_stall  = (state_r != S_IDLE) || !rst_n;
  assign in_fire   = in_valid && !in_stall;
  assign done_fire = (state_r == S_DONE) && !(out_valid_r && out_stall);

  // edge order: v0-v1, v1-v2, v2-v0, each as x, y, z
  assign dif_in[0] = abs_diff(in_p0_x, in_p1_x);
  assign dif_in[1] = abs_diff(in_p0_y, in_p1_y);
  assign dif_in[2] = abs_diff(in_p0_z, in_p1_z);
  assign dif_in[3] = abs_diff(in_p1_x, in_p2_x);
  assign dif_in[4] = abs_diff(in_p1_y, in_p2_y);
  assign dif_in[5] = abs_diff(in_p1_z, in_p2_z);
  assign dif_in[6] = abs_diff(in_p2_x, in_p0_x);
  assign dif_in[7] = abs_diff(in_p2_y, in_p0_y);
  assign dif_in[8] = abs_diff(in_p2_z, in_p0_z);

  // Heron factors; a set top bit marks a factor gone negative after truncation
  assign per_c = hta_pkg::OP_W'(ea_r) + hta_pkg::OP_W'(eb_r) + hta_pkg::OP_W'(ec_r);
  assign f1_c  = hta_pkg::OP_W'(eb_r) + hta_pkg::OP_W'(ec_r) - hta_pkg::OP_W'(ea_r);
  assign f2_c  = hta_pkg::OP_W'(ea_r) + hta_pkg::OP_W'(ec_r) - hta_pkg::OP_W'(eb_r);
  assign f3_c  = hta_pkg::OP_W'(ea_r) + hta_pkg::OP_W'(eb_r) - hta_pkg::OP_W'(ec_r);
  assign heron_neg = f1_c[hta_pkg::OP_W-1] | f2_c[hta_pkg::OP_W-1] | f3_c[hta_pkg::OP_W-1];

  // shared multiplier operands
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state_r == S_EMUL) begin
      op_a = hta_pkg::OP_W'(dif_r[0]);
      op_b = hta_pkg::OP_W'(dif_r[0]);
    end else begin
      case (hstep_r)
        hta_pkg::HS_P1: begin
          op_a = per_r;
          op_b = hta_pkg::OP_W'(f1_r);
        end
        hta_pkg::HS_P2: begin
          op_a = hta_pkg::OP_W'(f2_r);
          op_b = hta_pkg::OP_W'(f3_r);
        end
        hta_pkg::HS_LL: begin
          op_a = p1_r[hta_pkg::OP_W-1:0];
          op_b = p2_r[hta_pkg::OP_W-1:0];
        end
        hta_pkg::HS_LH: begin
          op_a = p1_r[hta_pkg::OP_W-1:0];
          op_b = hta_pkg::OP_W'(p2_r[hta_pkg::P2_W-1:hta_pkg::OP_W]);
        end
        hta_pkg::HS_HL: begin
          op_a = hta_pkg::OP_W'(p1_r[hta_pkg::P1_W-1:hta_pkg::OP_W]);
          op_b = p2_r[hta_pkg::OP_W-1:0];
        end
        hta_pkg::HS_HH: begin
          op_a = hta_pkg::OP_W'(p1_r[hta_pkg::P1_W-1:hta_pkg::OP_W]);
          op_b = hta_pkg::OP_W'(p2_r[hta_pkg::P2_W-1:hta_pkg::OP_W]);
        end
        default: begin
          op_a = '0;
          op_b = '0;
        end
      endcase
    end
  end

  assign prod_ext = hta_pkg::RAD_W'(mul_r);

  always_comb begin
    case (hstep_r)
      hta_pkg::HS_LH, hta_pkg::HS_HL: addend = prod_ext << hta_pkg::OP_W;
      hta_pkg::HS_HH:                 addend = prod_ext << (2 * hta_pkg::OP_W);
      default:                        addend = prod_ext;
    endcase
  end

  assign root_sh  = sq_sts.root >> AREA_SHIFT;
  assign area_sat = (|root_sh[hta_pkg::ROOT_W-1:hta_pkg::AREA_W]) ? '1
                                                                  : root_sh[hta_pkg::AREA_W-1:0];

  assign total_sum = {1'b0, running_total_r} + {1'b0, area_r};
  assign total_sat = total_sum[hta_pkg::AREA_W] ? '1 : total_sum[hta_pkg::AREA_W-1:0];

  assign sq_cmd.start = (state_r == S_ESQ) || (state_r == S_HSQ);
  assign sq_cmd.wide  = (state_r == S_HSQ);

  hta_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (sq_cmd),
    .radicand (acc_r),
    .sts      (sq_sts)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_EMUL;
      S_EMUL:  state_nxt = S_EACC;
      S_EACC:  state_nxt = (comp_r == 2'(hta_pkg::NUM_AXES - 1)) ? S_ESQ : S_EMUL;
      S_ESQ:   state_nxt = S_EWAIT;
      S_EWAIT: begin
        if (sq_sts.done) begin
          state_nxt = (edge_r == 2'(hta_pkg::NUM_AXES - 1)) ? S_PREP : S_EMUL;
        end
      end
      S_PREP:  state_nxt = heron_neg ? S_DONE : S_HMUL;
      S_HMUL:  state_nxt = S_HACC;
      S_HACC:  state_nxt = (hstep_r == hta_pkg::HS_HH) ? S_HSQ : S_HMUL;
      S_HSQ:   state_nxt = S_HWAIT;
      S_HWAIT: if (sq_sts.done) state_nxt = S_DONE;
      S_DONE:  if (done_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      comp_r          <= '0;
      edge_r          <= '0;
      hstep_r         <= hta_pkg::HS_P1;
      out_valid_r     <= 1'b0;
      running_total_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        comp_r <= '0;
        edge_r <= '0;
      end
      if (state_r == S_EACC) begin
        comp_r <= (comp_r == 2'(hta_pkg::NUM_AXES - 1)) ? 2'd0 : comp_r + 2'd1;
      end
      if ((state_r == S_EWAIT) && sq_sts.done) begin
        edge_r <= edge_r + 2'd1;
      end
      if (state_r == S_PREP) begin
        hstep_r <= hta_pkg::HS_P1;
      end
      if (state_r == S_HACC) begin
        hstep_r <= hta_pkg::hstep_t'(hstep_r + 3'd1);
      end
      // hold the result while stalled; drop valid once the beat is taken
      if (done_fire) begin
        out_valid_r     <= 1'b1;
        running_total_r <= last_r ? '0 : total_sat;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      dif_r  <= dif_in;
      last_r <= in_is_last_triangle;
      acc_r  <= '0;
    end
    if ((state_r == S_EMUL) || (state_r == S_HMUL)) begin
      mul_r <= hta_pkg::PROD_W'(op_a) * hta_pkg::PROD_W'(op_b);
    end
    if (state_r == S_EACC) begin
      acc_r <= acc_r + prod_ext;
      for (int i = 0; i < hta_pkg::NUM_DIFF - 1; i++) begin
        dif_r[i] <= dif_r[i+1];
      end
    end
    if ((state_r == S_EWAIT) && sq_sts.done) begin
      ea_r  <= eb_r;
      eb_r  <= ec_r;
      ec_r  <= sq_sts.root[hta_pkg::EDGE_W-1:0];
      acc_r <= '0;
    end
    if (state_r == S_PREP) begin
      per_r  <= per_c;
      f1_r   <= f1_c[hta_pkg::F_W-1:0];
      f2_r   <= f2_c[hta_pkg::F_W-1:0];
      f3_r   <= f3_c[hta_pkg::F_W-1:0];
      area_r <= '0;
    end
    if (state_r == S_HACC) begin
      case (hstep_r)
        hta_pkg::HS_P1: p1_r  <= mul_r[hta_pkg::P1_W-1:0];
        hta_pkg::HS_P2: p2_r  <= mul_r[hta_pkg::P2_W-1:0];
        default:        acc_r <= acc_r + addend;
      endcase
    end
    if ((state_r == S_HWAIT) && sq_sts.done) begin
      area_r <= area_sat;
    end
    if (done_fire) begin
      out_tri_r  <= area_r;
      out_poly_r <= total_sat;
      out_done_r <= last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_triangle_area = out_tri_r;
  assign out_polygon_area  = out_poly_r;
  assign out_polygon_done  = out_done_r;

  `HTA_ASSERT_IMP(a_sq_start_idle, sq_cmd.start, !sq_sts.busy)
  `HTA_ASSERT_IMP(a_poly_ge_tri, out_valid_r, out_poly_r >= out_tri_r)
  `HTA_ASSERT_NXT(a_total_clear, done_fire && last_r, running_total_r == '0)
  `HTA_ASSERT_NXT(a_degen_zero, (state_r == S_PREP) && heron_neg, area_r == '0)

endmodule
